// ===== hw/rtl/cascaded_pt_lowpass_core_assert.svh =====
// Assertion macros for the cascaded low-pass filter core.
`ifndef CASCADED_PT_LOWPASS_CORE_ASSERT_SVH
`define CASCADED_PT_LOWPASS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cpl_pkg.sv =====
// Shared constants and types for the cascaded low-pass filter core.
`timescale 1ns / 1ps

package cpl_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int CHAN_W      = 2;
  localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STAGE_W     = 32;
  localparam int FRAC_BITS   = 8;
  localparam int GAIN_W      = 16;
  localparam int MODE_W      = 2;
  localparam int STAGES      = 3;
  localparam int STG_W       = $clog2(STAGES);
  localparam int PROD_W      = GAIN_W + 1 + STAGE_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYPASS = 2'd0,
    MODE_PT1    = 2'd1,
    MODE_PT2    = 2'd2,
    MODE_PT3    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE    = 1'd0,
    CFG_SMOOTHING_GAIN = 1'd1
  } cfg_idx_t;

  typedef logic signed [STAGE_W-1:0] stage_t;
  typedef logic [STAGES-1:0][STAGE_W-1:0] stage_word_t;

endpackage

// ===== hw/rtl/cpl_if.sv =====
// Valid/ready channel interfaces for the sample input and the filtered output.
`timescale 1ns / 1ps

interface cpl_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [cpl_pkg::CHAN_W-1:0]              channel;
  logic signed [cpl_pkg::SAMPLE_BITS-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface cpl_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [cpl_pkg::CHAN_W-1:0]              out_channel;
  logic signed [cpl_pkg::SAMPLE_BITS-1:0]  filtered;

  modport source (output valid, output out_channel, output filtered, input ready);
  modport sink (input valid, input out_channel, input filtered, output ready);
endinterface

// ===== hw/rtl/cascaded_pt_lowpass_core.sv =====
// Cascaded first-order low-pass filter core, up to three stages per channel.
// One beat in gives one beat out. Each channel keeps three 32-bit stage values (8 fraction
// bits) in a small synchronous memory, one word per channel; a beat reads its channel's word,
// runs the active stages one after another through a single 17x33 multiplier, and writes
// the word back. A new beat is accepted only once the previous result has gone to the output
// register. Pass-through beats and channels beyond the configured count leave the stages
// untouched. Each active stage runs a multiply state followed by its accumulate state.
// Stage memory reads as zero after reset until a channel is first written, with no clearing
// pass. Write filter_mode and smoothing_gain only while idle.
`timescale 1ns / 1ps

`include "cascaded_pt_lowpass_core_assert.svh"

module cascaded_pt_lowpass_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  cpl_in_if.sink                           in_port,
  cpl_out_if.source                        out_port
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                                   state_r, state_nxt;
  cpl_pkg::mode_t                           mode_r;
  logic [cpl_pkg::GAIN_W-1:0]               gain_r;

  cpl_pkg::stage_word_t                     stage_mem_r [cpl_pkg::CHANNELS];
  logic [cpl_pkg::CHANNELS-1:0]             vld_r;
  cpl_pkg::stage_word_t                     rd_word_r;
  logic                                     rd_vld_r;

  logic [cpl_pkg::CHAN_W-1:0]               ch_r;
  cpl_pkg::stage_word_t                     word_r;
  cpl_pkg::stage_t                          stage_in_r;
  logic signed [cpl_pkg::PROD_W-1:0]        prod_r;
  logic [cpl_pkg::STG_W-1:0]                stg_r;
  logic [cpl_pkg::STG_W-1:0]                last_r;
  logic [cpl_pkg::SAMPLE_BITS-1:0]          res_r;

  logic                                     out_valid_r;
  logic [cpl_pkg::CHAN_W-1:0]               out_channel_r;
  logic [cpl_pkg::SAMPLE_BITS-1:0]          out_filtered_r;

  logic                                     in_acc;
  logic                                     bypass;
  logic                                     out_free;
  logic                                     mem_we;
  cpl_pkg::stage_t                          cur;
  logic signed [cpl_pkg::STAGE_W:0]         diff;
  logic signed [cpl_pkg::PROD_W-1:0]        prod;
  cpl_pkg::stage_t                          nv;
  cpl_pkg::stage_t                          nv_shift;
  cpl_pkg::stage_word_t                     wr_word;
  cpl_pkg::stage_t                          scaled;

  assign in_port.ready        = (state_r == S_IDLE);
  assign in_acc               = in_port.valid && in_port.ready;
  assign bypass               = (mode_r == cpl_pkg::MODE_BYPASS) ||
                                (32'(in_port.channel) >= 32'(cpl_pkg::CHANNELS));
  assign out_free             = !out_valid_r || out_port.ready;
  assign out_port.valid       = out_valid_r;
  assign out_port.out_channel = out_channel_r;
  assign out_port.filtered    = out_filtered_r;

  assign scaled   = cpl_pkg::STAGE_W'(in_port.sample) <<< cpl_pkg::FRAC_BITS;
  assign cur      = word_r[stg_r];
  assign diff     = (cpl_pkg::STAGE_W + 1)'(stage_in_r) - (cpl_pkg::STAGE_W + 1)'(cur);
  assign prod     = cpl_pkg::PROD_W'($signed({1'b0, gain_r})) * cpl_pkg::PROD_W'(diff);
  assign nv       = cur + prod_r[cpl_pkg::GAIN_W +: cpl_pkg::STAGE_W];
  assign nv_shift = nv >>> cpl_pkg::FRAC_BITS;
  assign mem_we   = (state_r == S_ADD) && (stg_r == last_r);

  always_comb begin
    wr_word        = word_r;
    wr_word[stg_r] = nv;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = bypass ? S_DONE : S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ADD;
      S_ADD: begin
        state_nxt = (stg_r == last_r) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= cpl_pkg::MODE_BYPASS;
      gain_r      <= '0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cpl_pkg::cfg_idx_t'(cfg_index))
          cpl_pkg::CFG_FILTER_MODE:
            mode_r <= cpl_pkg::mode_t'(cfg_wdata[cpl_pkg::MODE_W-1:0]);
          cpl_pkg::CFG_SMOOTHING_GAIN:
            gain_r <= cfg_wdata[cpl_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        vld_r[ch_r[cpl_pkg::CH_AW-1:0]] <= 1'b1;
      end
    end
  end

  // stage memory: read on accept, write back after the last active stage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stage_mem_r[ch_r[cpl_pkg::CH_AW-1:0]] <= wr_word;
    end
    if (in_acc) begin
      rd_word_r <= stage_mem_r[in_port.channel[cpl_pkg::CH_AW-1:0]];
      rd_vld_r  <= vld_r[in_port.channel[cpl_pkg::CH_AW-1:0]];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ch_r       <= in_port.channel;
          stage_in_r <= scaled;
          res_r      <= in_port.sample;
          stg_r      <= '0;
          last_r     <= cpl_pkg::STG_W'(mode_r) - cpl_pkg::STG_W'(1);
        end
      end
      S_LOAD: begin
        word_r <= rd_vld_r ? rd_word_r : '0;
      end
      S_MUL: begin
        prod_r <= prod;
      end
      S_ADD: begin
        word_r[stg_r] <= nv;
        stage_in_r    <= nv;
        stg_r         <= stg_r + cpl_pkg::STG_W'(1);
        if (stg_r == last_r) begin
          res_r <= nv_shift[cpl_pkg::SAMPLE_BITS-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_channel_r  <= ch_r;
          out_filtered_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  `CPL_ASSERT_NEXT(a_bypass_direct, clk, rst_n, in_acc && bypass,
    (state_r == S_DONE) && (res_r == $past(in_port.sample)),
    "bypass beat did not pass the sample straight through")
  `CPL_ASSERT_NOW(a_stage_bound, clk, rst_n, (state_r == S_MUL) || (state_r == S_ADD),
    stg_r <= last_r, "stage index ran past the last active stage")
  `CPL_ASSERT_NEXT(a_writeback_done, clk, rst_n, mem_we,
    (state_r == S_DONE) && vld_r[ch_r[cpl_pkg::CH_AW-1:0]],
    "write-back not followed by result hand-off")

endmodule
